### hw/rtl/sliding_window_kth_smallest_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sliding window rank filter
// Clocked on clk and gated off during reset.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_KTH_SMALLEST_CORE_MACROS_SVH
`define SLIDING_WINDOW_KTH_SMALLEST_CORE_MACROS_SVH

// Same-cycle implication.
`define SWK_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define SWK_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/swk_pkg.sv
// ----------------------------------------------------------------------------
// swk_pkg
// Shared types and constants of the sliding window rank filter.
// ----------------------------------------------------------------------------
package swk_pkg;

	// config port
	localparam int CFG_W     = 7;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_RANK        = 1'b1;

	localparam logic [CFG_W-1:0] WINDOW_SIZE_RST = 7'd3;
	localparam logic [CFG_W-1:0] RANK_RST        = 7'd1;

	// controller -> datapath
	typedef struct packed {
		logic accept;    // take sample, touch the arrival FIFO
		logic rm_step;   // one step of the removal scan
		logic ins_rd;    // fetch the top entry for insertion
		logic ins_step;  // one step of the insertion scan
		logic put;       // write the new sample at entry 0
		logic res_rd;    // fetch the ranked entry
		logic res_load;  // load the output register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic full;      // window already full
		logic n_zero;    // nothing to insert behind
		logic rm_last;   // removal scan at last entry
		logic ins_gt;    // fetched entry above the new sample
		logic di_zero;   // scan index at entry 0
		logic emit;      // this request gives a result
		logic out_busy;  // output register held by a stall
	} status_t;

endpackage

### hw/rtl/swk_ctrl.sv
// ----------------------------------------------------------------------------
// swk_ctrl
// Sequencer for one request: removal scan, insertion scan, result fetch.
// ----------------------------------------------------------------------------
module swk_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             sample_valid,
	output logic             sample_ready,
	input  swk_pkg::status_t status,
	output swk_pkg::cmd_t    cmd
);
	import swk_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_RM     = 7'b0000010,
		S_INS_RD = 7'b0000100,
		S_INS    = 7'b0001000,
		S_PUT    = 7'b0010000,
		S_RES_RD = 7'b0100000,
		S_RES    = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	state_t done_state;

	assign done_state   = status.emit ? S_RES_RD : S_IDLE;
	assign sample_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (sample_valid) begin
					cmd.accept = 1'b1;
					state_d    = status.full ? S_RM : S_INS_RD;
				end
			end
			S_RM: begin
				cmd.rm_step = 1'b1;
				if (status.rm_last) state_d = S_INS_RD;
			end
			S_INS_RD: begin
				if (status.n_zero) begin
					cmd.put = 1'b1;
					state_d = done_state;
				end else begin
					cmd.ins_rd = 1'b1;
					state_d    = S_INS;
				end
			end
			S_INS: begin
				cmd.ins_step = 1'b1;
				if (!status.ins_gt) state_d = done_state;
				else if (status.di_zero) state_d = S_PUT;
			end
			S_PUT: begin
				cmd.put = 1'b1;
				state_d = done_state;
			end
			S_RES_RD: begin
				cmd.res_rd = 1'b1;
				state_d    = S_RES;
			end
			S_RES: begin
				if (!status.out_busy) begin
					cmd.res_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end

endmodule

### hw/rtl/swk_dpath.sv
// ----------------------------------------------------------------------------
// swk_dpath
// Arrival FIFO and sorted window memories, scan counters, config and output.
// ----------------------------------------------------------------------------
module swk_dpath #(
	parameter int MAX_WINDOW   = 64,
	parameter int SAMPLE_WIDTH = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  swk_pkg::cmd_t                  cmd,
	output swk_pkg::status_t               status,
	input  logic                           cfg_we,
	input  logic [swk_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [swk_pkg::CFG_W-1:0]      cfg_data,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	output logic                           kth_value_valid,
	input  logic                           kth_value_ready,
	output logic signed [SAMPLE_WIDTH-1:0] kth_value
);
	import swk_pkg::*;

	localparam int ADDR_W = $clog2(MAX_WINDOW);
	localparam int CNT_W  = $clog2(MAX_WINDOW + 1);

	logic signed [SAMPLE_WIDTH-1:0] sort_mem [MAX_WINDOW];
	logic signed [SAMPLE_WIDTH-1:0] fifo_mem [MAX_WINDOW];

	logic [CFG_W-1:0]  win_size_q, rank_q;
	logic [CNT_W-1:0]  fill_q;
	logic [ADDR_W-1:0] ptr_q, di_q, n_q;
	logic              found_q, emit_q, kth_valid_q;

	logic signed [SAMPLE_WIDTH-1:0] key_q, old_q, sort_rd_q, kth_value_q;

	logic [CNT_W-1:0]  eff_w, eff_r, ptr_inc;
	logic [ADDR_W-1:0] ptr_eff, ptr_next, res_addr;
	logic              full;

	logic              sort_re, sort_we;
	logic [ADDR_W-1:0] sort_raddr, sort_waddr;
	logic signed [SAMPLE_WIDTH-1:0] sort_wdata;
	logic              ins_gt;

	// effective window and rank
	always_comb begin
		if (win_size_q == '0)                 eff_w = CNT_W'(1);
		else if (int'(win_size_q) > MAX_WINDOW) eff_w = CNT_W'(MAX_WINDOW);
		else                                  eff_w = CNT_W'(win_size_q);

		if (rank_q == '0)                     eff_r = CNT_W'(1);
		else if (int'(rank_q) > int'(eff_w))  eff_r = eff_w;
		else                                  eff_r = CNT_W'(rank_q);
	end

	assign res_addr = ADDR_W'(eff_r - CNT_W'(1));
	assign full     = (fill_q >= eff_w);
	assign ptr_eff  = (CNT_W'(ptr_q) >= eff_w) ? '0 : ptr_q;
	assign ptr_inc  = CNT_W'(ptr_eff) + CNT_W'(1);
	assign ptr_next = (ptr_inc >= eff_w) ? '0 : ADDR_W'(ptr_inc);
	assign ins_gt   = (sort_rd_q > key_q);

	// sorted memory port control
	always_comb begin
		sort_re    = 1'b0;
		sort_raddr = '0;
		sort_we    = 1'b0;
		sort_waddr = '0;
		sort_wdata = sort_rd_q;
		if (cmd.accept && full) begin
			sort_re = 1'b1;
		end
		if (cmd.rm_step) begin
			sort_re    = 1'b1;
			sort_raddr = di_q + ADDR_W'(1);
			sort_we    = found_q;
			sort_waddr = di_q - ADDR_W'(1);
		end
		if (cmd.ins_rd) begin
			sort_re    = 1'b1;
			sort_raddr = n_q - ADDR_W'(1);
		end
		if (cmd.ins_step) begin
			sort_re    = 1'b1;
			sort_raddr = di_q - ADDR_W'(1);
			sort_we    = 1'b1;
			sort_waddr = di_q + ADDR_W'(1);
			sort_wdata = ins_gt ? sort_rd_q : key_q;
		end
		if (cmd.put) begin
			sort_we    = 1'b1;
			sort_wdata = key_q;
		end
		if (cmd.res_rd) begin
			sort_re    = 1'b1;
			sort_raddr = res_addr;
		end
	end

	always_ff @(posedge clk) begin
		if (sort_re) sort_rd_q <= sort_mem[sort_raddr];
		if (sort_we) sort_mem[sort_waddr] <= sort_wdata;
	end

	// arrival FIFO: read-first, so the oldest sample is read and replaced at once
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			if (full) begin
				old_q              <= fifo_mem[ptr_eff];
				fifo_mem[ptr_eff]  <= sample;
			end else begin
				fifo_mem[ADDR_W'(fill_q)] <= sample;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept)   key_q       <= sample;
		if (cmd.res_load) kth_value_q <= sort_rd_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_size_q  <= WINDOW_SIZE_RST;
			rank_q      <= RANK_RST;
			fill_q      <= '0;
			ptr_q       <= '0;
			di_q        <= '0;
			n_q         <= '0;
			found_q     <= 1'b0;
			emit_q      <= 1'b0;
			kth_valid_q <= 1'b0;
		end else begin
			if (cmd.accept) begin
				found_q <= 1'b0;
				di_q    <= '0;
				if (full) begin
					n_q    <= ADDR_W'(eff_w - CNT_W'(1));
					ptr_q  <= ptr_next;
					fill_q <= eff_w;
					emit_q <= 1'b1;
				end else begin
					n_q    <= ADDR_W'(fill_q);
					fill_q <= fill_q + CNT_W'(1);
					emit_q <= ((fill_q + CNT_W'(1)) == eff_w);
				end
			end
			if (cmd.rm_step) begin
				di_q <= di_q + ADDR_W'(1);
				if (!found_q && (sort_rd_q == old_q)) found_q <= 1'b1;
			end
			if (cmd.ins_rd)   di_q <= n_q - ADDR_W'(1);
			if (cmd.ins_step) di_q <= di_q - ADDR_W'(1);

			if (cmd.res_load)         kth_valid_q <= 1'b1;
			else if (kth_value_ready) kth_valid_q <= 1'b0;

			if (cfg_we) begin
				case (cfg_index)
					REG_WINDOW_SIZE: begin
						win_size_q <= cfg_data;
						fill_q     <= '0;
						ptr_q      <= '0;
					end
					REG_RANK: rank_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	assign status.full     = full;
	assign status.n_zero   = (n_q == '0);
	assign status.rm_last  = (CNT_W'(di_q) == (eff_w - CNT_W'(1)));
	assign status.ins_gt   = ins_gt;
	assign status.di_zero  = (di_q == '0);
	assign status.emit     = emit_q;
	assign status.out_busy = kth_valid_q && !kth_value_ready;

	assign kth_value_valid = kth_valid_q;
	assign kth_value       = kth_value_q;

endmodule

### hw/rtl/sliding_window_kth_smallest_core.sv
// ----------------------------------------------------------------------------
// sliding_window_kth_smallest_core
// Streaming rank-order filter. Each request carries one signed sample. The
// last window_size samples are kept in arrival order in a FIFO memory and in
// ascending order in a second memory. While the window fills, a request only
// stores its sample and gives no result; the request that fills it returns a
// result, and every one after first drops one copy of the oldest sample from
// the sorted copy, then inserts the new one after any equal values, and
// returns the rank-th smallest value
// (rank 1 is the minimum). window_size 0 acts as 1 and saturates at
// MAX_WINDOW; rank 0 acts as 1 and saturates at the window. Writing
// window_size flushes the window; writing rank keeps it. One request is in
// work at a time. With a full window of W entries a request walks the
// sorted memory one entry per cycle: first across all W entries to close the
// gap of the removed sample, then down from the top to open the slot for the
// new one, then one read for the result. While filling, a request inserts
// its sample the same way and fetches the result when it is due. A result
// stalled in the output register holds the sequencer before the load of the
// next result, and so holds off the next request.
// ----------------------------------------------------------------------------
module sliding_window_kth_smallest_core #(
	parameter int MAX_WINDOW   = 64,
	parameter int SAMPLE_WIDTH = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,

	// config write port
	input  logic                           cfg_we,
	input  logic [swk_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [swk_pkg::CFG_W-1:0]      cfg_data,

	// sample requests
	input  logic                           sample_valid,
	output logic                           sample_ready,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,

	// results
	output logic                           kth_value_valid,
	input  logic                           kth_value_ready,
	output logic signed [SAMPLE_WIDTH-1:0] kth_value
);
	import swk_pkg::*;

	cmd_t    cmd;     // sequencer commands
	status_t status;  // datapath flags back to the sequencer

	// sequencer: idle, removal scan, insertion scan, result fetch
	swk_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.status       (status),
		.cmd          (cmd)
	);

	// memories, counters, config registers and the output register
	swk_dpath #(
		.MAX_WINDOW   (MAX_WINDOW),
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.sample          (sample),
		.kth_value_valid (kth_value_valid),
		.kth_value_ready (kth_value_ready),
		.kth_value       (kth_value)
	);

endmodule

### hw/rtl/swk_checker.sv
// ----------------------------------------------------------------------------
// swk_checker
// Port-level checks of the rank filter, bound to the top level.
// ----------------------------------------------------------------------------
`include "sliding_window_kth_smallest_core_macros.svh"

module swk_checker #(
	parameter int SAMPLE_WIDTH = 32
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           sample_valid,
	input logic                           sample_ready,
	input logic                           kth_value_valid,
	input logic                           kth_value_ready,
	input logic signed [SAMPLE_WIDTH-1:0] kth_value
);

	// a stalled result stays put
	`SWK_ASSERT_NEXT(a_out_held, kth_value_valid && !kth_value_ready, kth_value_valid, "result dropped under stall")

	// one request in work at a time
	`SWK_ASSERT_NEXT(a_one_in_work, sample_valid && sample_ready, !sample_ready, "second request taken during work")

	// a new result only comes out of a busy sequencer
	`SWK_ASSERT_NOW(a_result_from_work, $rose(kth_value_valid), !$past(sample_ready), "result without work")

	// stalled result value is stable
	`SWK_ASSERT_NEXT(a_out_stable, kth_value_valid && !kth_value_ready, $stable(kth_value), "result changed under stall")

endmodule

bind sliding_window_kth_smallest_core swk_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_chk (
	.clk             (clk),
	.arst_n          (arst_n),
	.sample_valid    (sample_valid),
	.sample_ready    (sample_ready),
	.kth_value_valid (kth_value_valid),
	.kth_value_ready (kth_value_ready),
	.kth_value       (kth_value)
);

### bench/sliding_window_kth_smallest_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sliding_window_kth_smallest_core_tb
// Self-checking bench for the streaming rank-order filter. A queue of
// pending samples feeds a valid/ready driver. A clocked monitor models the
// window (arrival order plus sorted copy) for every accepted request and
// checks each result against the oldest predicted kth value. Directed
// extremes and duplicate runs come first. Random phases follow across
// several window/rank settings, with bursty idling on both sides and one
// long output stall.
// ----------------------------------------------------------------------------
module sliding_window_kth_smallest_core_tb;

	import swk_pkg::*;

	localparam int MAX_WIN  = 64;
	localparam int SAMPLE_W = 32;

	// covers the longest request, with margin on top
	localparam int DRAIN_CYCLES   = 2 * MAX_WIN + 16;
	localparam int LONG_HOLD      = 300;
	localparam int WATCHDOG_LIMIT = 4000;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	localparam sample_t S_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
	localparam sample_t S_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_W-1:0]      cfg_data;
	logic                  sample_valid;
	logic                  sample_ready;
	sample_t               sample;
	logic                  kth_value_valid;
	logic                  kth_value_ready;
	sample_t               kth_value;

	// stimulus side
	sample_t pending_q[$];
	int      items_queued   = 0;
	int      items_accepted = 0;
	bit      sample_taken   = 1'b0;   // request accepted at the last rising edge
	int      send_gap       = 0;
	int      send_odds;               // 1-in-N chance of an idle burst, 0 = none
	int      recv_stall     = 0;
	int      recv_odds;
	int      hold_asks      = 0;      // long output stalls requested by the sequence
	int      hold_done      = 0;
	int      hold_left      = 0;

	// window model
	logic [CFG_W-1:0] window_cfg = WINDOW_SIZE_RST;
	logic [CFG_W-1:0] rank_cfg   = RANK_RST;
	sample_t          sorted_q[$];
	sample_t          arrival_mem[MAX_WIN];
	int               fill_cnt   = 0;
	int               oldest_idx = 0;

	// scoreboard
	sample_t kth_expected_q[$];
	int      mismatches = 0;
	int      quiet_cycles = 0;

	sliding_window_kth_smallest_core #(
		.MAX_WINDOW  (MAX_WIN),
		.SAMPLE_WIDTH(SAMPLE_W)
	) u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.sample_valid   (sample_valid),
		.sample_ready   (sample_ready),
		.sample         (sample),
		.kth_value_valid(kth_value_valid),
		.kth_value_ready(kth_value_ready),
		.kth_value      (kth_value)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Window model: one accepted sample in, at most one kth value out.
	// Full window: drop one copy of the oldest sample, then insert the new
	// one after all equal values. Filling: just store and insert.
	// ------------------------------------------------------------------
	function automatic bit rank_filter_step(input sample_t s, output sample_t kth);
		int      w;
		int      r;
		int      i;
		int      pos;
		sample_t oldest;
		w   = (window_cfg == 0) ? 1 : ((window_cfg > MAX_WIN) ? MAX_WIN : int'(window_cfg));
		kth = '0;
		if (fill_cnt >= w) begin
			if (oldest_idx >= w)
				oldest_idx = 0;
			oldest = arrival_mem[oldest_idx];
			i = 0;
			while (i < sorted_q.size() && sorted_q[i] != oldest)
				i++;
			if (i >= sorted_q.size())
				i = sorted_q.size() - 1;
			sorted_q.delete(i);
			arrival_mem[oldest_idx] = s;
			oldest_idx++;
			if (oldest_idx >= w)
				oldest_idx = 0;
			fill_cnt = w;
		end else begin
			arrival_mem[fill_cnt] = s;
			fill_cnt++;
		end
		// new value lands behind any equal ones
		pos = 0;
		while (pos < sorted_q.size() && sorted_q[pos] <= s)
			pos++;
		sorted_q.insert(pos, s);
		if (fill_cnt != w)
			return 1'b0;
		// rank 0 acts as 1, rank past the window clamps to the window
		r = (rank_cfg == 0) ? 1 : int'(rank_cfg);
		if (r > w)
			r = w;
		kth = sorted_q[r-1];
		return 1'b1;
	endfunction

	// Mostly full-range values, plenty of tiny ones for duplicates, some rails.
	function automatic sample_t pick_sample();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return sample_t'($urandom);
			4, 5, 6:    return sample_t'($urandom_range(0, 8)) - 4;
			7:          return ($urandom_range(0, 1) != 0) ? S_MAX : S_MIN;
			8:          return S_MAX - sample_t'($urandom_range(0, 3));
			default:    return S_MIN + sample_t'($urandom_range(0, 3));
		endcase
	endfunction

	task automatic queue_sample(input sample_t v);
		pending_q.insert(pending_q.size(), v);
		items_queued++;
	endtask

	task automatic random_burst(input int n);
		repeat (n)
			queue_sample(pick_sample());
	endtask

	// Called at a falling edge with the block idle. Model tracks the write
	// immediately: a window write flushes, a rank write keeps the window.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] d);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		if (idx == REG_WINDOW_SIZE) begin
			window_cfg = d;
			fill_cnt   = 0;
			oldest_idx = 0;
			sorted_q.delete();
		end else if (idx == REG_RANK) begin
			rank_cfg = d;
		end
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic reconfigure(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] r);
		write_reg(REG_WINDOW_SIZE, w);
		write_reg(REG_RANK, r);
	endtask

	// Every request taken and every result back, then let a trailing
	// no-result request finish before touching the registers.
	task automatic wait_idle();
		do
			@(negedge clk);
		while (items_accepted != items_queued || kth_expected_q.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = '0;
		cfg_data        = '0;
		send_odds       = 6;
		recv_odds       = 6;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset registers (window 3, rank 1): rails and neighbors of zero
		queue_sample(S_MIN);
		queue_sample(S_MAX);
		queue_sample(0);
		queue_sample(-1);
		queue_sample(1);
		queue_sample(S_MAX);
		queue_sample(S_MAX);
		wait_idle();

		// window 0 behaves as 1, rank 0 as 1: every sample comes straight back
		reconfigure(7'd0, 7'd0);
		queue_sample(S_MAX);
		queue_sample(S_MIN);
		queue_sample(0);
		wait_idle();

		// rank past the window picks the max; duplicate runs exercise
		// single-copy removal and insert-after-equals
		reconfigure(7'd4, 7'd9);
		queue_sample(5);
		queue_sample(5);
		queue_sample(-3);
		queue_sample(5);
		queue_sample(5);
		queue_sample(-3);
		queue_sample(S_MIN);
		wait_idle();

		// rank change alone keeps the window contents
		write_reg(REG_RANK, 7'd2);
		queue_sample(5);
		queue_sample(-3);
		queue_sample(7);
		wait_idle();

		// random phases
		reconfigure(7'd1, 7'd1);
		random_burst(60);
		wait_idle();

		send_odds = 0;
		recv_odds = 4;
		reconfigure(7'd2, 7'd2);
		random_burst(80);
		wait_idle();

		// long output stall while the sender keeps pushing: input backs up
		send_odds = 12;
		recv_odds = 12;
		reconfigure(7'd5, 7'd3);
		hold_asks++;
		random_burst(150);
		wait_idle();

		write_reg(REG_RANK, 7'd5);
		random_burst(60);
		wait_idle();

		send_odds = 3;
		recv_odds = 0;
		reconfigure(7'd8, 7'd0);
		random_burst(100);
		wait_idle();

		send_odds = 5;
		recv_odds = 5;
		reconfigure(7'd16, 7'd127);
		random_burst(120);
		wait_idle();

		// largest windows are slow: keep these phases short
		reconfigure(7'd64, 7'd32);
		random_burst(90);
		wait_idle();

		reconfigure(7'd127, 7'd64);
		random_burst(80);
		wait_idle();

		send_odds = 4;
		recv_odds = 8;
		reconfigure(7'($urandom_range(2, 12)), 7'($urandom_range(0, 15)));
		random_burst(200);
		wait_idle();

		// closing stretch at full rate on both sides
		send_odds = 0;
		recv_odds = 0;
		reconfigure(7'd7, 7'd4);
		random_burst(100);
		wait_idle();

		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// ------------------------------------------------------------------
	// Request driver: holds a request until taken, then either idles for a
	// burst or presents the next pending sample.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (!arst_n) begin
			sample_valid <= 1'b0;
		end else if (sample_valid && !sample_taken) begin
			// still waiting on ready, payload stays put
		end else if (send_gap > 0) begin
			send_gap--;
			sample_valid <= 1'b0;
		end else if (pending_q.size() == 0) begin
			sample_valid <= 1'b0;
		end else if (send_odds != 0 && $urandom_range(1, send_odds) == 1) begin
			send_gap = $urandom_range(1, 10) - 1;
			sample_valid <= 1'b0;
		end else begin
			sample       <= pending_q[0];
			pending_q.delete(0);
			sample_valid <= 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// Result receiver: random stall bursts, plus one long hold-off counted
	// here when the sequence asks for it.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (!arst_n) begin
			kth_value_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			kth_value_ready <= 1'b0;
		end else if (hold_done != hold_asks) begin
			hold_done++;
			hold_left = LONG_HOLD - 1;
			kth_value_ready <= 1'b0;
		end else if (recv_stall > 0) begin
			recv_stall--;
			kth_value_ready <= 1'b0;
		end else if (recv_odds != 0 && $urandom_range(1, recv_odds) == 1) begin
			recv_stall = $urandom_range(1, 10) - 1;
			kth_value_ready <= 1'b0;
		end else begin
			kth_value_ready <= 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// Monitor: predict on each accepted request, then check each accepted
	// result against the oldest prediction. Prediction first, so even a
	// same-edge result would find its entry.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : monitor
		sample_t predicted;
		sample_t want;
		bit      gives;
		if (arst_n) begin
			sample_taken = sample_valid && sample_ready;
			if (sample_taken) begin
				items_accepted++;
				gives = rank_filter_step(sample, predicted);
				if (gives)
					kth_expected_q.insert(kth_expected_q.size(), predicted);
			end
			if (kth_value_valid && kth_value_ready) begin
				if (kth_expected_q.size() == 0) begin
					$display("%0t: kth_value expected none, actual %0d", $time, kth_value);
					mismatches++;
				end else begin
					want = kth_expected_q[0];
					kth_expected_q.delete(0);
					if (kth_value !== want) begin
						$display("%0t: kth_value expected %0d, actual %0d",
							$time, want, kth_value);
						mismatches++;
					end
				end
			end
		end
	end

	// Watchdog: too long with nothing moving on either channel.
	always @(posedge clk) begin
		if ((arst_n && sample_valid && sample_ready) || (kth_value_valid && kth_value_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

endmodule
